// ----- rtl/pooled_bump_suballocator_defines.svh -----
// Assertion macros for the pooled bump suballocator.
`ifndef POOLED_BUMP_SUBALLOCATOR_DEFINES_SVH
`define POOLED_BUMP_SUBALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbs assertion failed");
`define PBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbs assertion failed");
`else
`define PBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/pbs_pkg.sv -----
`default_nettype none
package pbs_pkg;

    localparam int CFG_W      = 40;
    localparam int SLOT_OUT_W = 4;
    localparam int TYPE_W     = 5;
    localparam int ALIGN_W    = 5;

    localparam logic [CFG_W-1:0] POOL_SIZE_RESET = 40'd16777216;

    localparam logic STATUS_GRANTED = 1'b0;
    localparam logic STATUS_NO_SLOT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_FIT,
        ST_PICK
    } pbs_state_t;

    typedef struct packed {
        logic load;
        logic align;
        logic fit;
        logic commit;
    } pbs_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/pbs_ctrl.sv -----
`default_nettype none
`include "pooled_bump_suballocator_defines.svh"
module pbs_ctrl
    import pbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output pbs_cmd_t      cmd
);

    pbs_state_t state_reg;
    pbs_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                cmd.align  = 1'b1;
                state_next = ST_FIT;
            end
            ST_FIT:
            begin
                cmd.fit    = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `PBS_ASSERT_IMPLY(a_out_from_pick, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_PICK)
    `PBS_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && !in_stall, state_reg == ST_ALIGN)

endmodule
`default_nettype wire

// ----- rtl/pbs_datapath.sv -----
`default_nettype none
`include "pooled_bump_suballocator_defines.svh"
module pbs_datapath
    import pbs_pkg::*;
#(
    parameter int POOL_SLOTS = 16,
    parameter int SIZE_BITS  = 40
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pbs_cmd_t              cmd,
    input  wire logic                  pool_size_we,
    input  wire logic [CFG_W-1:0]      pool_size,
    input  wire logic [CFG_W-1:0]      req_size,
    input  wire logic [ALIGN_W-1:0]    req_align_log2,
    input  wire logic [TYPE_W-1:0]     mem_type,
    output logic                       status,
    output logic [SLOT_OUT_W-1:0]      pool_slot,
    output logic [CFG_W-1:0]           aligned_offset,
    output logic                       new_pool
);

    localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int PW     = (SIZE_BITS > CFG_W) ? SIZE_BITS : CFG_W;
    localparam int EW     = SIZE_BITS + 32;

    logic [PW-1:0]        pool_size_reg;
    logic [SIZE_BITS-1:0] req_size_reg;
    logic [ALIGN_W-1:0]   req_lg_reg;
    logic [TYPE_W-1:0]    req_type_reg;

    logic [POOL_SLOTS-1:0] slot_valid_reg;
    logic [TYPE_W-1:0]     slot_type_reg [POOL_SLOTS];
    logic [PW-1:0]         slot_cap_reg  [POOL_SLOTS];
    logic [SIZE_BITS-1:0]  slot_fill_reg [POOL_SLOTS];

    logic [SIZE_BITS-1:0]  align_reg [POOL_SLOTS];
    logic [SIZE_BITS-1:0]  align_next [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] align_ok_reg;
    logic [POOL_SLOTS-1:0] align_ok_next;
    logic [POOL_SLOTS-1:0] fit_reg;
    logic [POOL_SLOTS-1:0] fit_next;
    logic                  big_reg;

    logic [31:0]      mask;
    logic [EW-1:0]    rnd [POOL_SLOTS];
    logic             hit_any;
    logic [SLOT_W-1:0] hit_idx;
    logic             free_any;
    logic [SLOT_W-1:0] free_idx;
    logic             take_hit;
    logic             take_new;
    logic [SIZE_BITS-1:0] hit_off;

    logic                  status_reg;
    logic [SLOT_OUT_W-1:0] pool_slot_reg;
    logic [CFG_W-1:0]      aligned_offset_reg;
    logic                  new_pool_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= PW'(POOL_SIZE_RESET);
        end
        else if (pool_size_we)
        begin
            pool_size_reg <= PW'(SIZE_BITS'(pool_size));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_size_reg <= SIZE_BITS'(req_size);
            req_lg_reg   <= req_align_log2;
            req_type_reg <= mem_type;
        end
    end

    assign mask = (32'd1 << req_lg_reg) - 32'd1;

    always_comb
    begin
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            rnd[i]           = (EW'(slot_fill_reg[i]) + EW'(mask)) & ~EW'(mask);
            align_next[i]    = rnd[i][SIZE_BITS-1:0];
            align_ok_next[i] = slot_valid_reg[i] && (slot_type_reg[i] == req_type_reg)
                               && (rnd[i][EW-1:SIZE_BITS] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.align)
        begin
            align_reg    <= align_next;
            align_ok_reg <= align_ok_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            fit_next[i] = align_ok_reg[i]
                && (((PW+1)'(align_reg[i]) + (PW+1)'(req_size_reg))
                    <= (PW+1)'(slot_cap_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fit)
        begin
            fit_reg <= fit_next;
            big_reg <= PW'(req_size_reg) > pool_size_reg;
        end
    end

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--)
        begin
            if (fit_reg[i])
            begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign take_hit = !big_reg && hit_any;
    assign take_new = !take_hit && free_any;
    assign hit_off  = align_reg[hit_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (cmd.commit && take_new)
        begin
            slot_valid_reg[free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (take_hit)
            begin
                slot_fill_reg[hit_idx] <= hit_off + req_size_reg;
            end
            else if (take_new)
            begin
                slot_type_reg[free_idx] <= req_type_reg;
                slot_cap_reg[free_idx]  <= big_reg ? PW'(req_size_reg) : pool_size_reg;
                slot_fill_reg[free_idx] <= req_size_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (take_hit)
            begin
                status_reg         <= STATUS_GRANTED;
                pool_slot_reg      <= SLOT_OUT_W'(hit_idx);
                aligned_offset_reg <= CFG_W'(hit_off);
                new_pool_reg       <= 1'b0;
            end
            else if (take_new)
            begin
                status_reg         <= STATUS_GRANTED;
                pool_slot_reg      <= SLOT_OUT_W'(free_idx);
                aligned_offset_reg <= '0;
                new_pool_reg       <= 1'b1;
            end
            else
            begin
                status_reg         <= STATUS_NO_SLOT;
                pool_slot_reg      <= '0;
                aligned_offset_reg <= '0;
                new_pool_reg       <= 1'b0;
            end
        end
    end

    assign status         = status_reg;
    assign pool_slot      = pool_slot_reg;
    assign aligned_offset = aligned_offset_reg;
    assign new_pool       = new_pool_reg;

    `PBS_ASSERT_NEXT(a_slots_never_freed, clk, rst_n, 1'b1, $countones(slot_valid_reg) >= $past($countones(slot_valid_reg)))
    `PBS_ASSERT_IMPLY(a_no_slot_only_full, clk, rst_n, $past(cmd.commit) && (status_reg == STATUS_NO_SLOT), &slot_valid_reg)
    `PBS_ASSERT_NEXT(a_claim_sets_valid, clk, rst_n, cmd.commit && take_new, $countones(slot_valid_reg) == $past($countones(slot_valid_reg)) + 1)

endmodule
`default_nettype wire

// ----- rtl/pooled_bump_suballocator.sv -----
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------------
//  request   | in_valid / in_stall     | req_size, req_align_log2, mem_type
//  result    | out_valid / out_stall   | status, pool_slot, aligned_offset, new_pool
//  config    | pool_size_we            | pool_size
//
//  Steps per request, in order: accept, align all pools, fit all pools, pick and update.
//  The pick step waits while the previous result is still stalled at the output.
//  Pools are checked in parallel; a priority encoder picks the lowest fitting slot.
//  Reset clears all slot valid bits at once and loads pool_size with 16777216.
//  The next request is taken while a finished result waits to be taken.
`default_nettype none
module pooled_bump_suballocator
    import pbs_pkg::*;
#(
    parameter int POOL_SLOTS = 16,
    parameter int SIZE_BITS  = 40
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pool_size_we,
    input  wire logic [CFG_W-1:0]      pool_size,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CFG_W-1:0]      req_size,
    input  wire logic [ALIGN_W-1:0]    req_align_log2,
    input  wire logic [TYPE_W-1:0]     mem_type,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       status,
    output logic [SLOT_OUT_W-1:0]      pool_slot,
    output logic [CFG_W-1:0]           aligned_offset,
    output logic                       new_pool
);

    pbs_cmd_t cmd;

    pbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    pbs_datapath #(
        .POOL_SLOTS (POOL_SLOTS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .pool_size_we   (pool_size_we),
        .pool_size      (pool_size),
        .req_size       (req_size),
        .req_align_log2 (req_align_log2),
        .mem_type       (mem_type),
        .status         (status),
        .pool_slot      (pool_slot),
        .aligned_offset (aligned_offset),
        .new_pool       (new_pool)
    );

endmodule
`default_nettype wire

// ----- verif/tb_pooled_bump_suballocator.sv -----
`timescale 1ns / 1ps
module tb_pooled_bump_suballocator;
    import pbs_pkg::*;

    localparam int SLOTS = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam logic [CFG_W-1:0] SIZE_MAX = '1;

    typedef struct packed {
        logic                  status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [CFG_W-1:0]      offset;
        logic                  fresh;
    } grant_t;

    class grant_tracker;
        bit                pool_live [SLOTS];
        logic [TYPE_W-1:0] pool_type [SLOTS];
        logic [CFG_W-1:0]  pool_cap  [SLOTS];
        logic [CFG_W-1:0]  pool_fill [SLOTS];
        logic [CFG_W-1:0]  pool_bytes;
        grant_t            pending_grants[$];
        int                mismatches;

        function new();
            pool_bytes = POOL_SIZE_RESET;
            mismatches = 0;
            foreach (pool_live[i])
            begin
                pool_live[i] = 1'b0;
                pool_type[i] = '0;
                pool_cap[i]  = '0;
                pool_fill[i] = '0;
            end
        endfunction

        function void set_pool_size(logic [CFG_W-1:0] value);
            pool_bytes = value;
        endfunction

        function grant_t predict_grant(logic [CFG_W-1:0] size, logic [ALIGN_W-1:0] lg,
                                       logic [TYPE_W-1:0] mt);
            grant_t           g;
            logic [CFG_W-1:0] mask;
            logic [CFG_W:0]   aligned;
            int               hit;
            g    = '0;
            hit  = -1;
            mask = (40'd1 << lg) - 40'd1;
            if (size <= pool_bytes)
            begin
                for (int i = 0; i < SLOTS && hit < 0; i++)
                begin
                    aligned = ({1'b0, pool_fill[i]} + {1'b0, mask}) & ~{1'b0, mask};
                    if (pool_live[i] && pool_type[i] == mt && !aligned[CFG_W] &&
                        aligned[CFG_W-1:0] <= pool_cap[i] &&
                        size <= pool_cap[i] - aligned[CFG_W-1:0])
                    begin
                        hit = i;
                        g.offset = aligned[CFG_W-1:0];
                    end
                end
            end
            if (hit >= 0)
            begin
                pool_fill[hit] = g.offset + size;
                g.status = STATUS_GRANTED;
                g.slot   = SLOT_OUT_W'(hit);
                return g;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!pool_live[i])
                begin
                    pool_live[i] = 1'b1;
                    pool_type[i] = mt;
                    pool_cap[i]  = (size > pool_bytes) ? size : pool_bytes;
                    pool_fill[i] = size;
                    g.status = STATUS_GRANTED;
                    g.slot   = SLOT_OUT_W'(i);
                    g.fresh  = 1'b1;
                    return g;
                end
            end
            g.status = STATUS_NO_SLOT;
            return g;
        endfunction

        function void note_request(logic [CFG_W-1:0] size, logic [ALIGN_W-1:0] lg,
                                   logic [TYPE_W-1:0] mt);
            grant_t g;
            g = predict_grant(size, lg, mt);
            pending_grants.insert(pending_grants.size(), g);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_grant(logic st, logic [SLOT_OUT_W-1:0] slot, logic [CFG_W-1:0] offset,
                         logic fresh);
            grant_t want;
            if (pending_grants.size() == 0)
            begin
                report_mismatch("result transfer with no request outstanding");
                return;
            end
            want = pending_grants.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status %0h, want %0h", st, want.status));
            if (slot !== want.slot)
                report_mismatch($sformatf("pool_slot %0d, want %0d", slot, want.slot));
            if (offset !== want.offset)
                report_mismatch($sformatf("aligned_offset %0h, want %0h", offset, want.offset));
            if (fresh !== want.fresh)
                report_mismatch($sformatf("new_pool %0h, want %0h", fresh, want.fresh));
        endtask
    endclass

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  pool_size_we   = 1'b0;
    logic [CFG_W-1:0]      pool_size      = POOL_SIZE_RESET;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [CFG_W-1:0]      req_size       = '0;
    logic [ALIGN_W-1:0]    req_align_log2 = '0;
    logic [TYPE_W-1:0]     mem_type       = '0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic                  status;
    logic [SLOT_OUT_W-1:0] pool_slot;
    logic [CFG_W-1:0]      aligned_offset;
    logic                  new_pool;

    grant_tracker      sb = new();
    bit                gaps_on = 1'b1;
    bit                stalls_on = 1'b1;
    int                stall_left = 0;
    logic [TYPE_W-1:0] busy_types[6] = '{5'd0, 5'd31, 5'd5, 5'd10, 5'd3, 5'd17};

    pooled_bump_suballocator DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .pool_size_we   (pool_size_we),
        .pool_size      (pool_size),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_size       (req_size),
        .req_align_log2 (req_align_log2),
        .mem_type       (mem_type),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .pool_slot      (pool_slot),
        .aligned_offset (aligned_offset),
        .new_pool       (new_pool)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_W-1:0] rand_upto(logic [CFG_W-1:0] limit);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return CFG_W'(r % ({24'd0, limit} + 64'd1));
    endfunction

    function automatic logic [CFG_W-1:0] rand_size();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[CFG_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= pick_gap();
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(req_size, req_align_log2, mem_type);
            if (out_valid && !out_stall)
                sb.check_grant(status, pool_slot, aligned_offset, new_pool);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_pooled_bump_suballocator failed");
        $finish;
    end

    task automatic offer_request(logic [CFG_W-1:0] size, logic [ALIGN_W-1:0] lg,
                                 logic [TYPE_W-1:0] mt);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_size       <= size;
        req_align_log2 <= lg;
        mem_type       <= mt;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_pool_size(logic [CFG_W-1:0] value);
        drain_results();
        pool_size_we <= 1'b1;
        pool_size    <= value;
        @(posedge clk);
        pool_size_we <= 1'b0;
        sb.set_pool_size(value);
    endtask

    task automatic offer_random_request();
        logic [CFG_W-1:0]   size;
        logic [ALIGN_W-1:0] lg;
        logic [TYPE_W-1:0]  mt;
        if ($urandom_range(0, 99) < 90)
        begin
            mt = busy_types[$urandom_range(0, 5)];
            case ($urandom_range(0, 3))
                0: size = '0;
                1: size = CFG_W'($urandom_range(1, 64));
                2: size = rand_upto(sb.pool_bytes >> 6);
                default: size = rand_upto(sb.pool_bytes);
            endcase
            lg = ($urandom_range(0, 3) == 0) ? ALIGN_W'($urandom_range(0, 31))
                                             : ALIGN_W'($urandom_range(0, 6));
        end
        else
        begin
            size = rand_size() >> $urandom_range(0, 39);
            lg   = ALIGN_W'($urandom_range(0, 31));
            mt   = TYPE_W'($urandom_range(0, 31));
        end
        offer_request(size, lg, mt);
    endtask

    task automatic run_random_phase(logic [CFG_W-1:0] psize, int count);
        write_pool_size(psize);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            offer_random_request();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-size claims and hits, alignment rounding, exact fit
        offer_request(40'd0, 5'd0, 5'd0);
        offer_request(40'd0, 5'd0, 5'd0);
        offer_request(40'd100, 5'd4, 5'd0);
        offer_request(40'd28, 5'd5, 5'd0);
        offer_request(40'd16776960, 5'd8, 5'd0);
        offer_request(40'd0, 5'd0, 5'd0);
        offer_request(40'd1, 5'd0, 5'd0);
        // oversize request, then rounding past the offset width
        offer_request(SIZE_MAX, 5'd31, 5'd31);
        offer_request(40'd0, 5'd31, 5'd31);
        offer_request(40'd0, 5'd0, 5'd31);
        offer_request(40'd1, 5'd31, 5'd31);

        write_pool_size(40'd0);
        offer_request(40'd0, 5'd3, 5'd5);
        offer_request(40'd0, 5'd31, 5'd5);
        offer_request(40'd1, 5'd0, 5'd5);
        offer_request(40'd0, 5'd0, 5'd5);

        write_pool_size(SIZE_MAX);
        offer_request(40'h80_0000_0000, 5'd31, 5'd10);
        offer_request(40'h7F_FFFF_FFFF, 5'd0, 5'd10);
        offer_request(40'd1, 5'd0, 5'd10);

        run_random_phase(40'd4096, 280);
        run_random_phase(40'd1048576, 280);
        run_random_phase(rand_size() | 40'd1, 280);
        run_random_phase(40'd0, 280);
        run_random_phase(SIZE_MAX, 280);
        // fill the table and run into no free slot
        for (int i = 0; i < 20; i++)
            offer_request(SIZE_MAX - CFG_W'(i), ALIGN_W'($urandom_range(0, 31)),
                          TYPE_W'($urandom_range(0, 31)));

        drain_results();
        repeat (16) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_grants.size() == 0)
            $display("tb_pooled_bump_suballocator passed");
        else
            $display("tb_pooled_bump_suballocator failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pbs_pkg.sv
rtl/pbs_ctrl.sv
rtl/pbs_datapath.sv
rtl/pooled_bump_suballocator.sv
verif/tb_pooled_bump_suballocator.sv
